/* rtl/core/vzd_pkg.sv */
// Package for the varint zigzag stream decoder: item types, width codes and
// the value finishing function. No dependencies.
package vzd_pkg;

   localparam int unsigned MaxBytesDefault = 10;
   localparam int unsigned CountWidth      = 4;
   localparam int unsigned ValueWidth      = 64;
   localparam logic [7:0]  ContinueBit     = 8'h80;
   localparam logic [7:0]  GroupMask       = 8'h7f;

   typedef enum logic [1:0] {
      WIDTH_8  = 2'd0,
      WIDTH_16 = 2'd1,
      WIDTH_32 = 2'd2,
      WIDTH_64 = 2'd3
   } vzd_width_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [1:0] value_width;
      logic       is_signed;
   } vzd_req_type;

   typedef struct packed {
      logic [ValueWidth-1:0] decoded_value;
      logic [CountWidth-1:0] byte_count;
      logic                  overrun;
   } vzd_rsp_type;

   typedef struct packed {
      logic valid;
      logic advance;
   } vzd_stage_ctrl_type;

   // Truncates to the selected width, then optionally undoes the zigzag
   // mapping and sign-extends to the full 64 bits.
   function automatic logic [ValueWidth-1:0] finish_value(
      input logic [ValueWidth-1:0] raw,
      input logic [1:0]            wsel,
      input logic                  sgn
   );
      logic [ValueWidth-1:0] mask;
      logic [ValueWidth-1:0] sbit;
      logic [ValueWidth-1:0] u;
      logic [ValueWidth-1:0] half;
      case (vzd_width_type'(wsel))
         WIDTH_8: begin
            mask = 64'h0000_0000_0000_00ff;
            sbit = 64'h0000_0000_0000_0080;
         end
         WIDTH_16: begin
            mask = 64'h0000_0000_0000_ffff;
            sbit = 64'h0000_0000_0000_8000;
         end
         WIDTH_32: begin
            mask = 64'h0000_0000_ffff_ffff;
            sbit = 64'h0000_0000_8000_0000;
         end
         default: begin
            mask = 64'hffff_ffff_ffff_ffff;
            sbit = 64'h8000_0000_0000_0000;
         end
      endcase
      u = raw & mask;
      if (sgn) begin
         half = u >> 1;
         u = u[0] ? (~half & mask) : half;
         if (|(u & sbit)) begin
            u = u | ~mask;
         end
      end
      return u;
   endfunction

endpackage

/* rtl/core/vzd_req_if.sv */
// Input channel of the decoder: one encoded byte and its mode fields per item.
// Does not depend on vzd_pkg; payload widths are fixed.
interface vzd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic [1:0] value_width;
   logic       is_signed;

   modport source (output valid, output data_byte, output value_width,
                   output is_signed, input ready);
   modport sink (input valid, input data_byte, input value_width,
                 input is_signed, output ready);
endinterface

/* rtl/core/vzd_rsp_if.sv */
// Result channel of the decoder: one decoded value per finished varint.
// Widths follow the fixed result fields.
interface vzd_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] decoded_value;
   logic [3:0]  byte_count;
   logic        overrun;

   modport source (output valid, output decoded_value, output byte_count,
                   output overrun, input ready);
   modport sink (input valid, input decoded_value, input byte_count,
                 input overrun, output ready);
endinterface

/* rtl/core/vzd_in_reg.sv */
// Input register stage of the decoder. Holds one accepted item until the
// accumulate stage can take it. Depends on vzd_pkg.
module vzd_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  vzd_pkg::vzd_req_type req_item,
   input  logic                advance,
   output vzd_pkg::vzd_stage_ctrl_type stage_ctrl,
   output vzd_pkg::vzd_req_type stage_item
);
   import vzd_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   vzd_req_type item_ff;
   vzd_req_type item_in;

   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;
   assign item_in   = (req_ready && req_valid) ? req_item : item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign stage_ctrl.valid   = valid_ff;
   assign stage_ctrl.advance = advance;
   assign stage_item         = item_ff;
endmodule

/* rtl/core/vzd_accum.sv */
// Accumulate stage: merges each byte's group into the running value and, on
// the last byte or an overrun, forms the result. Depends on vzd_pkg.
module vzd_accum #(
   parameter int unsigned MAX_BYTES = vzd_pkg::MaxBytesDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  vzd_pkg::vzd_stage_ctrl_type stage_ctrl,
   input  vzd_pkg::vzd_req_type        stage_item,
   output logic                        rsp_valid,
   output vzd_pkg::vzd_rsp_type        rsp_item
);
   import vzd_pkg::*;

   localparam logic [CountWidth-1:0] MaxCount = CountWidth'(MAX_BYTES);

   logic [ValueWidth-1:0] acc_ff;
   logic [ValueWidth-1:0] acc_in;
   logic [CountWidth-1:0] idx_ff;
   logic [CountWidth-1:0] idx_in;
   logic [ValueWidth-1:0] merged;
   logic [6:0]            shift;
   logic [CountWidth-1:0] count;
   logic                  last_byte;
   logic                  overrun;
   logic                  take;

   assign take      = stage_ctrl.valid && stage_ctrl.advance;
   assign shift     = 7'(idx_ff) * 7'd7;
   assign merged    = (shift < 7'd64)
                    ? (acc_ff | (ValueWidth'(stage_item.data_byte & GroupMask) << shift[5:0]))
                    : acc_ff;
   assign count     = idx_ff + CountWidth'(1);
   assign last_byte = !(|(stage_item.data_byte & ContinueBit));
   assign overrun   = !last_byte && (count >= MaxCount);

   always_comb begin
      acc_in = acc_ff;
      idx_in = idx_ff;
      if (take) begin
         if (last_byte || overrun) begin
            acc_in = '0;
            idx_in = '0;
         end else begin
            acc_in = merged;
            idx_in = count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         idx_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         idx_ff <= idx_in;
      end
   end

   assign rsp_valid              = stage_ctrl.valid && (last_byte || overrun);
   assign rsp_item.decoded_value = overrun ? '0
                                 : finish_value(merged, stage_item.value_width,
                                                stage_item.is_signed);
   assign rsp_item.byte_count    = count;
   assign rsp_item.overrun       = overrun;
endmodule

/* rtl/core/vzd_out_reg.sv */
// Result register of the decoder. Holds a finished item until the sink takes
// it and tells the earlier stages when they may move. Depends on vzd_pkg.
module vzd_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rsp_valid,
   input  vzd_pkg::vzd_rsp_type rsp_item,
   output logic                 advance,
   output logic                 out_valid,
   input  logic                 out_ready,
   output vzd_pkg::vzd_rsp_type out_item
);
   import vzd_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   vzd_rsp_type item_ff;
   vzd_rsp_type item_in;

   assign advance  = !valid_ff || out_ready;
   assign valid_in = advance ? rsp_valid : valid_ff;
   assign item_in  = (advance && rsp_valid) ? rsp_item : item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

/* rtl/core/varint_zigzag_stream_decoder_unit.sv */
// Top level of the varint zigzag stream decoder: input register, accumulate
// stage and result register. Depends on vzd_pkg, vzd_req_if and vzd_rsp_if.
//
//   channel    direction  item
//   req_chan   in         data_byte, value_width, is_signed
//   rsp_chan   out        decoded_value, byte_count, overrun
//
// One byte is taken every cycle while rsp_chan does not stall; the result of the
// byte that ends a value passes the input register, then the result register.
// Bytes with bit 7 set before the limit produce no item.
// Reset is synchronous and clears the handshake state, accumulator and count.
// A stall on rsp_chan holds both stages; req_chan.ready drops only then.
module varint_zigzag_stream_decoder_unit #(
   parameter int unsigned MAX_BYTES = vzd_pkg::MaxBytesDefault
) (
   input logic clock,
   input logic reset,
   vzd_req_if.sink   req_chan,
   vzd_rsp_if.source rsp_chan
);
   import vzd_pkg::*;

   vzd_req_type        req_item;
   vzd_req_type        stage_item;
   vzd_stage_ctrl_type stage_ctrl;
   vzd_rsp_type        acc_item;
   vzd_rsp_type        out_item;
   logic               acc_valid;
   logic               advance;
   logic               req_ready;
   logic               out_valid;

   assign req_item.data_byte   = req_chan.data_byte;
   assign req_item.value_width = req_chan.value_width;
   assign req_item.is_signed   = req_chan.is_signed;
   assign req_chan.ready       = req_ready;

   vzd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .stage_ctrl (stage_ctrl),
      .stage_item (stage_item)
   );

   vzd_accum #(
      .MAX_BYTES (MAX_BYTES)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .stage_ctrl (stage_ctrl),
      .stage_item (stage_item),
      .rsp_valid  (acc_valid),
      .rsp_item   (acc_item)
   );

   vzd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .rsp_valid (acc_valid),
      .rsp_item  (acc_item),
      .advance   (advance),
      .out_valid (out_valid),
      .out_ready (rsp_chan.ready),
      .out_item  (out_item)
   );

   assign rsp_chan.valid         = out_valid;
   assign rsp_chan.decoded_value = out_item.decoded_value;
   assign rsp_chan.byte_count    = out_item.byte_count;
   assign rsp_chan.overrun       = out_item.overrun;
endmodule

/* tb/tb_varint_zigzag_stream_decoder_unit.sv */
// Self-checking testbench for the varint zigzag stream decoder unit.
// Drives directed and random byte streams through vzd_req_if, predicts each result
// and checks it on vzd_rsp_if; depends on vzd_pkg and both channel interfaces.
`timescale 1ns / 100ps

module tb_varint_zigzag_stream_decoder_unit;
   import vzd_pkg::*;

   localparam int MaxBytes     = MaxBytesDefault;
   localparam int ResetCycles  = 9;
   localparam int HoldCycles   = 300;
   localparam int IdleLimit    = 5000;
   localparam int SettleCycles = 12;
   localparam int PhaseBytes   = 160;
   localparam int ReportLimit  = 10;

   logic clock;
   logic reset;

   vzd_req_if req_chan ();
   vzd_rsp_if rsp_chan ();

   varint_zigzag_stream_decoder_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   vzd_req_type pending_bytes[$];
   vzd_rsp_type expected_values[$];

   logic [63:0] acc_value;
   logic [3:0]  bytes_taken;

   int src_idle_pct;
   int sink_stall_pct;
   int hold_requests;
   int holds_served;
   int hold_left;
   int idle_cycles;
   int failures;
   int mismatches;

   int src_pct_by_phase[4]  = '{0, 75, 0, 6};
   int sink_pct_by_phase[4] = '{0, 0, 75, 6};

   always #1 clock = ~clock;

   // Truncates to the chosen width; in zigzag mode the low bit becomes the sign.
   function automatic logic [63:0] narrow_value(input logic [63:0] raw,
                                                input vzd_width_type wsel,
                                                input logic zigzag);
      logic s;
      s = raw[0];
      case (wsel)
         WIDTH_8:  return zigzag ? {{57{s}}, raw[7:1] ^ {7{s}}} : {56'd0, raw[7:0]};
         WIDTH_16: return zigzag ? {{49{s}}, raw[15:1] ^ {15{s}}} : {48'd0, raw[15:0]};
         WIDTH_32: return zigzag ? {{33{s}}, raw[31:1] ^ {31{s}}} : {32'd0, raw[31:0]};
         default:  return zigzag ? {s, raw[63:1] ^ {63{s}}} : raw;
      endcase
   endfunction

   task automatic take_byte(input vzd_req_type item);
      vzd_rsp_type r;
      int shift;
      logic [3:0] count;
      shift = int'(bytes_taken) * 7;
      if (shift < 64) begin
         acc_value = acc_value | (64'(item.data_byte[6:0]) << shift);
      end
      count = bytes_taken + 4'd1;
      if (!item.data_byte[7]) begin
         r.decoded_value = narrow_value(acc_value, vzd_width_type'(item.value_width),
                                        item.is_signed);
         r.byte_count = count;
         r.overrun = 1'b0;
         expected_values.push_back(r);
         acc_value = '0;
         bytes_taken = '0;
      end else if (int'(count) >= MaxBytes) begin
         r.decoded_value = '0;
         r.byte_count = count;
         r.overrun = 1'b1;
         expected_values.push_back(r);
         acc_value = '0;
         bytes_taken = '0;
      end else begin
         bytes_taken = count;
      end
   endtask

   function automatic void queue_byte(input logic [7:0] data, input vzd_width_type wsel,
                                      input logic sgn);
      vzd_req_type item;
      item.data_byte = data;
      item.value_width = wsel;
      item.is_signed = sgn;
      pending_bytes.push_back(item);
   endfunction

   // Mostly well-formed varints of random length and content; the rest are
   // runs that hit the overrun limit and single random bytes.
   function automatic int queue_random_value();
      int kind;
      int len;
      logic more;
      kind = $urandom_range(99);
      if (kind < 8) begin
         queue_byte(8'($urandom), vzd_width_type'(2'($urandom)), 1'($urandom));
         return 1;
      end
      if (kind < 16) begin
         len = MaxBytes;
      end else if (kind < 26) begin
         len = MaxBytes;
      end else if (kind < 70) begin
         len = $urandom_range(1, 3);
      end else begin
         len = $urandom_range(1, MaxBytes);
      end
      for (int i = 0; i < len; i++) begin
         more = (i < len - 1) || (kind < 16);
         queue_byte({more, 7'($urandom)}, vzd_width_type'(2'($urandom)), 1'($urandom));
      end
      return len;
   endfunction

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_chan.valid || expected_values.size() != 0) begin
         @(negedge clock);
      end
   endtask

   always @(posedge clock) begin : drive_bytes
      vzd_req_type item;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
            item = pending_bytes.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.data_byte <= item.data_byte;
            req_chan.value_width <= item.value_width;
            req_chan.is_signed <= item.is_signed;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : track_bytes
      vzd_req_type item;
      if (reset) begin
         acc_value = '0;
         bytes_taken = '0;
      end else if (req_chan.valid && req_chan.ready) begin
         item.data_byte = req_chan.data_byte;
         item.value_width = req_chan.value_width;
         item.is_signed = req_chan.is_signed;
         take_byte(item);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left <= HoldCycles;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   always @(posedge clock) begin : check_values
      vzd_rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_values.size() == 0) begin
            failures++;
            mismatches++;
            if (mismatches <= ReportLimit) begin
               $display("unexpected result: value %h count %0d overrun %0b",
                        rsp_chan.decoded_value, rsp_chan.byte_count, rsp_chan.overrun);
            end
         end else begin
            want = expected_values.pop_front();
            if (rsp_chan.decoded_value !== want.decoded_value ||
                rsp_chan.byte_count !== want.byte_count ||
                rsp_chan.overrun !== want.overrun) begin
               failures++;
               mismatches++;
               if (mismatches <= ReportLimit) begin
                  $display("mismatch: expected value %h count %0d overrun %0b, got %h %0d %0b",
                           want.decoded_value, want.byte_count, want.overrun,
                           rsp_chan.decoded_value, rsp_chan.byte_count, rsp_chan.overrun);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("[varint_zigzag_stream_decoder_unit] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data_byte = '0;
      req_chan.value_width = '0;
      req_chan.is_signed = 1'b0;
      rsp_chan.ready = 1'b0;
      src_idle_pct = 0;
      sink_stall_pct = 0;
      hold_requests = 0;
      holds_served = 0;
      idle_cycles = 0;
      failures = 0;
      mismatches = 0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // Single-byte values: zero, odd zigzag at 32 bits, even zigzag at 64 bits.
      queue_byte(8'h00, WIDTH_8, 1'b0);
      queue_byte(8'h7f, WIDTH_32, 1'b1);
      queue_byte(8'h7e, WIDTH_64, 1'b1);
      // Ten-byte value whose last group overflows bit 63; the mode fields
      // change on every byte but only the last one counts.
      for (int i = 0; i < MaxBytes - 1; i++) begin
         queue_byte(8'hff, vzd_width_type'(2'(i)), 1'(i));
      end
      queue_byte(8'h7f, WIDTH_64, 1'b1);
      // Ten bytes with no terminator end in an overrun.
      for (int i = 0; i < MaxBytes; i++) begin
         queue_byte(8'h80 | 8'(i * 13), vzd_width_type'(2'(i + 1)), 1'(i));
      end
      queue_byte(8'h80, WIDTH_8, 1'b0);
      queue_byte(8'h02, WIDTH_16, 1'b1);
      @(negedge clock);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin : run_phase
         int queued;
         @(negedge clock);
         src_idle_pct = src_pct_by_phase[phase];
         sink_stall_pct = sink_pct_by_phase[phase];
         if (phase == 0) begin
            hold_requests++;
         end
         queued = 0;
         while (queued < PhaseBytes) begin
            queued += queue_random_value();
         end
         wait_drained();
      end

      repeat (SettleCycles) @(posedge clock);
      failures += expected_values.size();
      if (failures == 0) begin
         $display("[varint_zigzag_stream_decoder_unit] OK");
      end else begin
         $display("[varint_zigzag_stream_decoder_unit] ERROR");
      end
      $finish;
   end

endmodule
